// File: design/ccore_pkg.sv
// Shared types, constants and the instruction classifier of the CHIP-8 core.
package ccore_pkg;

  localparam int unsigned AddrW    = 12;
  localparam int unsigned MemDepth = 4096;
  localparam int unsigned NumRegs  = 16;
  localparam int unsigned NumRows  = 32;
  localparam int unsigned NumCols  = 64;

  localparam int unsigned StackDepthDef   = 16;
  localparam int unsigned ProgramStartDef = 512;
  localparam int unsigned FontBaseDef     = 80;

  localparam logic [4:0] NoKey = 5'd16;

  localparam logic [1:0] FaultNone = 2'd0;
  localparam logic [1:0] FaultHalt = 2'd1;
  localparam logic [1:0] FaultOvf  = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_EXEC = 2'd1,
    OP_TICK = 2'd2,
    OP_ROW  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CLS_SIMPLE,
    CLS_BAD,
    CLS_CALL,
    CLS_RET,
    CLS_DRAW,
    CLS_BCD,
    CLS_SAVE,
    CLS_RESTORE
  } cls_e;

  typedef enum logic [3:0] {
    U_NOP,
    U_START,
    U_FETCH_HI,
    U_FETCH_LO,
    U_TAKE_LO,
    U_TAKE_VY,
    U_EXEC,
    U_RET_RD,
    U_RET_WR,
    U_DRAW_RD,
    U_DRAW_WR,
    U_BCD,
    U_SAVE,
    U_RESTORE_RD,
    U_RESTORE_WR,
    U_PUBLISH
  } uop_e;

  typedef struct packed {
    uop_e uop;
  } cmd_t;

  typedef struct packed {
    cls_e cls;
    logic halted;
    logic last;
    logic zero_n;
    logic ret_ok;
  } status_t;

  function automatic cls_e classify(input logic [15:0] w);
    cls_e c;
    c = CLS_BAD;
    unique case (w[15:12])
      4'h0: begin
        if (w == 16'h00E0) c = CLS_SIMPLE;
        else if (w == 16'h00EE) c = CLS_RET;
      end
      4'h2: c = CLS_CALL;
      4'h5, 4'h9: if (w[3:0] == 4'h0) c = CLS_SIMPLE;
      4'h8: if (w[3] == 1'b0 || w[3:0] == 4'hE) c = CLS_SIMPLE;
      4'hD: c = CLS_DRAW;
      4'hE: if (w[7:0] == 8'h9E || w[7:0] == 8'hA1) c = CLS_SIMPLE;
      4'hF: begin
        unique case (w[7:0])
          8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29: c = CLS_SIMPLE;
          8'h33:   c = CLS_BCD;
          8'h55:   c = CLS_SAVE;
          8'h65:   c = CLS_RESTORE;
          default: c = CLS_BAD;
        endcase
      end
      default: c = CLS_SIMPLE;
    endcase
    return c;
  endfunction

endpackage

// File: design/ccore_ram.sv
// Generic RAM: one write port, one read port with registered read data.
module ccore_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/ccore_datapath.sv
// Datapath of the CHIP-8 core: memory, registers, stack, timers and display.
module ccore_datapath #(
  parameter int unsigned STACK_DEPTH   = 16,
  parameter int unsigned PROGRAM_START = 512,
  parameter int unsigned FONT_BASE     = 80
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ccore_pkg::cmd_t     cmd_i,
  output ccore_pkg::status_t  status_o,
  input  logic [1:0]          op_i,
  input  logic [11:0]         addr_i,
  input  logic [7:0]          data_i,
  input  logic [15:0]         keys_i,
  input  logic [7:0]          random_byte_i,
  output logic [11:0]         pc_now_o,
  output logic [15:0]         instr_word_o,
  output logic                display_changed_o,
  output logic                sound_on_o,
  output logic [1:0]          fault_code_o,
  output logic                key_waiting_o,
  output logic [63:0]         row_pixels_o
);
  import ccore_pkg::*;

  localparam int unsigned SaW = $clog2(STACK_DEPTH);
  localparam int unsigned LvW = $clog2(STACK_DEPTH + 1);

  logic [AddrW-1:0] pc_q, pc_d, i_q, i_d;
  logic [LvW-1:0]   level_q, level_d;
  logic [7:0]       delay_q, delay_d, sound_q, sound_d;
  logic [7:0]       regs_q [NumRegs];
  logic [7:0]       regs_d [NumRegs];
  logic [63:0]      frame_q [NumRows];
  logic [63:0]      frame_d [NumRows];
  logic [4:0]       held_q, held_d;
  logic             halted_q, halted_d;

  logic [7:0]  hi_q, hi_d, lo_q, lo_d, vx_q, vx_d, vy_q, vy_d, rnd_q, rnd_d;
  logic [15:0] keys_q, keys_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        drew_q, drew_d, wait_q, wait_d, ovf_q, ovf_d, wordv_q, wordv_d;
  logic [63:0] row_q, row_d;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata, mem_rdata;
  logic             stk_we;
  logic [SaW-1:0]   stk_waddr, stk_raddr;
  logic [AddrW-1:0] stk_rdata;

  logic [3:0]  rsel;
  logic [7:0]  reg_rd;
  logic [15:0] word;
  logic [3:0]  x_idx;
  logic [7:0]  nn;
  logic [11:0] nnn;
  cls_e        cls;

  // Decimal digits of Vx: hundreds by compare, tens by reciprocal multiply.
  logic [1:0]  bcd_h;
  logic [7:0]  bcd_rem;
  logic [15:0] bcd_prod;
  logic [3:0]  bcd_t;
  logic [7:0]  bcd_o;
  logic [7:0]  bcd_digit;

  logic [5:0]  draw_row;
  logic [63:0] sprite;
  logic [12:0] isum;
  logic [8:0]  asum;
  logic [11:0] font_off;

  assign word  = {hi_q, lo_q};
  assign x_idx = hi_q[3:0];
  assign nn    = lo_q;
  assign nnn   = {hi_q[3:0], lo_q};
  assign cls   = classify(word);

  always_comb begin
    unique case (cmd_i.uop)
      U_TAKE_VY: rsel = lo_q[7:4];
      U_SAVE:    rsel = cnt_q;
      default:   rsel = hi_q[3:0];
    endcase
  end
  assign reg_rd = regs_q[rsel];

  always_comb begin
    if (vx_q >= 8'd200)      bcd_h = 2'd2;
    else if (vx_q >= 8'd100) bcd_h = 2'd1;
    else                     bcd_h = 2'd0;
    bcd_rem  = vx_q - 8'(bcd_h * 8'd100);
    bcd_prod = 16'(bcd_rem) * 16'd205;
    bcd_t    = bcd_prod[14:11];
    bcd_o    = bcd_rem - 8'(bcd_t * 8'd10);
    unique case (cnt_q[1:0])
      2'd0:    bcd_digit = {6'b0, bcd_h};
      2'd1:    bcd_digit = {4'b0, bcd_t};
      default: bcd_digit = bcd_o;
    endcase
  end

  assign draw_row = {1'b0, vy_q[4:0]} + {2'b0, cnt_q};
  assign sprite   = {mem_rdata, 56'b0} >> vx_q[5:0];
  assign isum     = {1'b0, i_q} + {5'b0, vx_q};
  assign font_off = {8'b0, vx_q[3:0]};

  always_comb begin
    pc_d = pc_q;  i_d = i_q;  level_d = level_q;
    delay_d = delay_q;  sound_d = sound_q;
    regs_d = regs_q;  frame_d = frame_q;
    held_d = held_q;  halted_d = halted_q;
    hi_d = hi_q;  lo_d = lo_q;  vx_d = vx_q;  vy_d = vy_q;
    rnd_d = rnd_q;  keys_d = keys_q;  cnt_d = cnt_q;
    drew_d = drew_q;  wait_d = wait_q;  ovf_d = ovf_q;  wordv_d = wordv_q;
    row_d = row_q;
    asum = {1'b0, vx_q} + {1'b0, vy_q};
    mem_we = 1'b0;  mem_waddr = addr_i;  mem_wdata = data_i;  mem_raddr = pc_q;
    stk_we = 1'b0;  stk_waddr = level_q[SaW-1:0];
    stk_raddr = SaW'(level_q - 1'b1);

    unique case (cmd_i.uop)
      U_START: begin
        keys_d = keys_i;  rnd_d = random_byte_i;
        drew_d = 1'b0;  wait_d = 1'b0;  ovf_d = 1'b0;  wordv_d = 1'b0;
        row_d = '0;
        unique case (op_i)
          OP_LOAD: mem_we = 1'b1;
          OP_TICK: begin
            if (delay_q != 8'd0) delay_d = delay_q - 8'd1;
            if (sound_q != 8'd0) sound_d = sound_q - 8'd1;
          end
          OP_ROW: if (addr_i < 12'd32) row_d = frame_q[addr_i[4:0]];
          default: ;
        endcase
      end
      U_FETCH_HI: mem_raddr = pc_q;
      U_FETCH_LO: begin
        mem_raddr = pc_q + 12'd1;
        hi_d = mem_rdata;
      end
      U_TAKE_LO: begin
        lo_d = mem_rdata;
        pc_d = pc_q + 12'd2;
        vx_d = reg_rd;
        wordv_d = 1'b1;
      end
      U_TAKE_VY: begin
        vy_d = reg_rd;
        cnt_d = '0;
      end
      U_EXEC: begin
        if (cls == CLS_BAD) begin
          halted_d = 1'b1;
        end else if (cls == CLS_CALL) begin
          pc_d = nnn;
          if (level_q < LvW'(STACK_DEPTH)) begin
            stk_we = 1'b1;
            level_d = level_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
        end else if (cls == CLS_SIMPLE || cls == CLS_DRAW) begin
          unique case (hi_q[7:4])
            4'h0: begin
              for (int r = 0; r < NumRows; r++) frame_d[r] = '0;
              drew_d = 1'b1;
            end
            4'h1: pc_d = nnn;
            4'h3: if (vx_q == nn) pc_d = pc_q + 12'd2;
            4'h4: if (vx_q != nn) pc_d = pc_q + 12'd2;
            4'h5: if (vx_q == vy_q) pc_d = pc_q + 12'd2;
            4'h6: regs_d[x_idx] = nn;
            4'h7: regs_d[x_idx] = vx_q + nn;
            4'h8: begin
              unique case (lo_q[3:0])
                4'h0: regs_d[x_idx] = vy_q;
                4'h1: begin regs_d[x_idx] = vx_q | vy_q; regs_d[15] = 8'd0; end
                4'h2: begin regs_d[x_idx] = vx_q & vy_q; regs_d[15] = 8'd0; end
                4'h3: begin regs_d[x_idx] = vx_q ^ vy_q; regs_d[15] = 8'd0; end
                4'h4: begin
                  regs_d[x_idx] = asum[7:0];
                  regs_d[15] = {7'b0, asum[8]};
                end
                4'h5: begin
                  regs_d[x_idx] = vx_q - vy_q;
                  regs_d[15] = {7'b0, vx_q >= vy_q};
                end
                4'h6: begin
                  regs_d[x_idx] = vy_q >> 1;
                  regs_d[15] = {7'b0, vy_q[0]};
                end
                4'h7: begin
                  regs_d[x_idx] = vy_q - vx_q;
                  regs_d[15] = {7'b0, vy_q >= vx_q};
                end
                4'hE: begin
                  regs_d[x_idx] = vy_q << 1;
                  regs_d[15] = {7'b0, vy_q[7]};
                end
                default: ;
              endcase
            end
            4'h9: if (vx_q != vy_q) pc_d = pc_q + 12'd2;
            4'hA: i_d = nnn;
            4'hB: pc_d = nnn + {4'b0, regs_q[0]};
            4'hC: regs_d[x_idx] = rnd_q & nn;
            4'hD: begin
              regs_d[15] = 8'd0;
              drew_d = 1'b1;
            end
            4'hE: begin
              if (nn == 8'h9E) begin
                if (keys_q[vx_q[3:0]]) pc_d = pc_q + 12'd2;
              end else if (!keys_q[vx_q[3:0]]) begin
                pc_d = pc_q + 12'd2;
              end
            end
            4'hF: begin
              unique case (nn)
                8'h07: regs_d[x_idx] = delay_q;
                8'h0A: begin
                  if (!held_q[4] && !keys_q[held_q[3:0]]) begin
                    regs_d[x_idx] = {4'b0, held_q[3:0]};
                    held_d = NoKey;
                  end else begin
                    for (int k = 0; k < NumRegs; k++) if (keys_q[k]) held_d = 5'(k);
                    pc_d = pc_q - 12'd2;
                    wait_d = 1'b1;
                  end
                end
                8'h15: delay_d = vx_q;
                8'h18: sound_d = vx_q;
                8'h1E: begin
                  regs_d[15] = {7'b0, isum[12]};
                  i_d = isum[11:0];
                end
                8'h29: i_d = (font_off << 2) + font_off + AddrW'(FONT_BASE);
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      U_RET_RD: ;
      U_RET_WR: begin
        pc_d = stk_rdata;
        level_d = level_q - 1'b1;
      end
      U_DRAW_RD: mem_raddr = i_q + {8'b0, cnt_q};
      U_DRAW_WR: begin
        if (!draw_row[5]) begin
          if ((frame_q[draw_row[4:0]] & sprite) != 64'd0) regs_d[15] = 8'd1;
          frame_d[draw_row[4:0]] = frame_q[draw_row[4:0]] ^ sprite;
        end
        cnt_d = cnt_q + 4'd1;
      end
      U_BCD: begin
        mem_we = 1'b1;
        mem_waddr = i_q + {8'b0, cnt_q};
        mem_wdata = bcd_digit;
        cnt_d = cnt_q + 4'd1;
      end
      U_SAVE: begin
        mem_we = 1'b1;
        mem_waddr = i_q;
        mem_wdata = reg_rd;
        i_d = i_q + 12'd1;
        cnt_d = cnt_q + 4'd1;
      end
      U_RESTORE_RD: begin
        mem_raddr = i_q;
        i_d = i_q + 12'd1;
      end
      U_RESTORE_WR: begin
        regs_d[cnt_q] = mem_rdata;
        cnt_d = cnt_q + 4'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= AddrW'(PROGRAM_START);
      i_q <= '0;
      level_q <= '0;
      delay_q <= '0;
      sound_q <= '0;
      for (int r = 0; r < NumRegs; r++) regs_q[r] <= '0;
      for (int r = 0; r < NumRows; r++) frame_q[r] <= '0;
      held_q <= NoKey;
      halted_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      i_q <= i_d;
      level_q <= level_d;
      delay_q <= delay_d;
      sound_q <= sound_d;
      regs_q <= regs_d;
      frame_q <= frame_d;
      held_q <= held_d;
      halted_q <= halted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;  lo_q <= lo_d;  vx_q <= vx_d;  vy_q <= vy_d;
    rnd_q <= rnd_d;  keys_q <= keys_d;  cnt_q <= cnt_d;
    drew_q <= drew_d;  wait_q <= wait_d;  ovf_q <= ovf_d;  wordv_q <= wordv_d;
    row_q <= row_d;
    if (cmd_i.uop == U_PUBLISH) begin
      pc_now_o          <= pc_q;
      instr_word_o      <= wordv_q ? word : 16'd0;
      display_changed_o <= drew_q;
      sound_on_o        <= (sound_q != 8'd0);
      fault_code_o      <= halted_q ? FaultHalt : (ovf_q ? FaultOvf : FaultNone);
      key_waiting_o     <= wait_q;
      row_pixels_o      <= row_q;
    end
  end

  ccore_ram #(.WIDTH(8), .DEPTH(MemDepth)) u_main_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ccore_ram #(.WIDTH(AddrW), .DEPTH(STACK_DEPTH)) u_stack_mem (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (pc_q),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  always_comb begin
    status_o.cls    = cls;
    status_o.halted = halted_q;
    status_o.zero_n = (lo_q[3:0] == 4'd0);
    status_o.ret_ok = (level_q != '0);
    unique case (cls)
      CLS_DRAW: status_o.last = (cnt_q == lo_q[3:0] - 4'd1);
      CLS_BCD:  status_o.last = (cnt_q == 4'd2);
      default:  status_o.last = (cnt_q == x_idx);
    endcase
  end

endmodule

// File: design/ccore_ctrl.sv
// Controller of the CHIP-8 core: sequences fetch, execute and result hand-off.
module ccore_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          op_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  ccore_pkg::status_t  status_i,
  output ccore_pkg::cmd_t     cmd_o
);
  import ccore_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH_HI,
    ST_FETCH_LO,
    ST_TAKE_LO,
    ST_TAKE_VY,
    ST_DISPATCH,
    ST_RET_RD,
    ST_RET_WR,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_BCD,
    ST_SAVE,
    ST_RESTORE_RD,
    ST_RESTORE_WR,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  uop_e   uop;

  always_comb begin
    state_d = state_q;
    uop = U_NOP;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) begin
        uop = U_START;
        state_d = (op_i == OP_EXEC && !status_i.halted) ? ST_FETCH_HI : ST_DONE;
      end
      ST_FETCH_HI: begin uop = U_FETCH_HI; state_d = ST_FETCH_LO; end
      ST_FETCH_LO: begin uop = U_FETCH_LO; state_d = ST_TAKE_LO; end
      ST_TAKE_LO:  begin uop = U_TAKE_LO;  state_d = ST_TAKE_VY; end
      ST_TAKE_VY:  begin uop = U_TAKE_VY;  state_d = ST_DISPATCH; end
      ST_DISPATCH: begin
        uop = U_EXEC;
        unique case (status_i.cls)
          CLS_RET:     state_d = status_i.ret_ok ? ST_RET_RD : ST_DONE;
          CLS_DRAW:    state_d = status_i.zero_n ? ST_DONE : ST_DRAW_RD;
          CLS_BCD:     state_d = ST_BCD;
          CLS_SAVE:    state_d = ST_SAVE;
          CLS_RESTORE: state_d = ST_RESTORE_RD;
          default:     state_d = ST_DONE;
        endcase
      end
      ST_RET_RD:  begin uop = U_RET_RD;  state_d = ST_RET_WR; end
      ST_RET_WR:  begin uop = U_RET_WR;  state_d = ST_DONE; end
      ST_DRAW_RD: begin uop = U_DRAW_RD; state_d = ST_DRAW_WR; end
      ST_DRAW_WR: begin
        uop = U_DRAW_WR;
        state_d = status_i.last ? ST_DONE : ST_DRAW_RD;
      end
      ST_BCD: begin
        uop = U_BCD;
        if (status_i.last) state_d = ST_DONE;
      end
      ST_SAVE: begin
        uop = U_SAVE;
        if (status_i.last) state_d = ST_DONE;
      end
      ST_RESTORE_RD: begin uop = U_RESTORE_RD; state_d = ST_RESTORE_WR; end
      ST_RESTORE_WR: begin
        uop = U_RESTORE_WR;
        state_d = status_i.last ? ST_DONE : ST_RESTORE_RD;
      end
      ST_DONE: if (!out_valid_q || !out_stall_i) begin
        uop = U_PUBLISH;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (uop == U_PUBLISH) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o.uop   = uop;

endmodule

// File: design/chip8_cpu_core.sv
// Top level of the CHIP-8 interpreter core: controller plus datapath.
//
//  channel  direction  handshake                 payload
//  in       to core    in_valid_i / in_stall_o   op, addr, data, keys, random_byte
//  out      from core  out_valid_o / out_stall_i pc_now, instr_word, display_changed,
//                                                sound_on, fault_code, key_waiting,
//                                                row_pixels
//
// Steps: a load, tick or row read goes from idle to done, which publishes the result.
// An execute goes through fetch-high, fetch-low, take-low, take-vy and dispatch before
// done; a sprite draw adds a read and a write step per row, Fx65 a read and a write
// step per register, Fx55 one per register, Fx33 one per digit and a return a stack
// read and a write. One memory read port and one register read port set these steps.
// Reset clears registers, timers, stack level and display at once; pc starts at
// PROGRAM_START. Input is taken only with the core idle. While a result is held by
// out_stall_i one more input item may transfer; it then waits in its final cycle,
// which holds off any further transfer until the pending result is taken.
module chip8_cpu_core #(
  parameter int unsigned STACK_DEPTH   = ccore_pkg::StackDepthDef,
  parameter int unsigned PROGRAM_START = ccore_pkg::ProgramStartDef,
  parameter int unsigned FONT_BASE     = ccore_pkg::FontBaseDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [11:0] addr_i,
  input  logic [7:0]  data_i,
  input  logic [15:0] keys_i,
  input  logic [7:0]  random_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] pc_now_o,
  output logic [15:0] instr_word_o,
  output logic        display_changed_o,
  output logic        sound_on_o,
  output logic [1:0]  fault_code_o,
  output logic        key_waiting_o,
  output logic [63:0] row_pixels_o
);
  import ccore_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequence each item through fetch, execute and hand-off.
  ccore_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Hold all machine state and the result register.
  ccore_datapath #(
    .STACK_DEPTH   (STACK_DEPTH),
    .PROGRAM_START (PROGRAM_START),
    .FONT_BASE     (FONT_BASE)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .op_i              (op_i),
    .addr_i            (addr_i),
    .data_i            (data_i),
    .keys_i            (keys_i),
    .random_byte_i     (random_byte_i),
    .pc_now_o          (pc_now_o),
    .instr_word_o      (instr_word_o),
    .display_changed_o (display_changed_o),
    .sound_on_o        (sound_on_o),
    .fault_code_o      (fault_code_o),
    .key_waiting_o     (key_waiting_o),
    .row_pixels_o      (row_pixels_o)
  );

endmodule
